/* rtl/aput_pkg.sv */
// Shared types, constants and the square-root step for the Adam update block.
`default_nettype none
package aput_pkg;
   localparam int DEFAULT_NUM_PARAMS = 4096;
   localparam int DEFAULT_QUEUE_DEPTH = 4;
   localparam int IDX_W = 12;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_BETA_FIRST = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_SECOND = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON_TERM = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE = 4'd3;

   localparam logic [15:0] BETA_FIRST_RST = 16'd58982;
   localparam logic [15:0] BETA_SECOND_RST = 16'd65470;
   localparam logic [15:0] EPSILON_TERM_RST = 16'd43;
   localparam logic [31:0] LEARNING_RATE_RST = 32'd4294967;
   localparam logic [31:0] ONE_Q32 = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic signed [31:0] gradient;
      logic signed [31:0] weight;
      logic [31:0]        rate;
   } item_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_type;

   function automatic sqrt_type sqrt_step(input sqrt_type cur, input logic [63:0] bit_val);
      sqrt_type    nxt;
      logic [64:0] trial;
      trial = {1'b0, cur.root} + {1'b0, bit_val};
      if ({1'b0, cur.rem} >= trial) begin
         nxt.rem = cur.rem - trial[63:0];
         nxt.root = (cur.root >> 1) + bit_val;
      end else begin
         nxt.rem = cur.rem;
         nxt.root = cur.root >> 1;
      end
      return nxt;
   endfunction
endpackage
`default_nettype wire

/* rtl/aput_front.sv */
// Front end: accepts items, recomputes the step rate at pass start, feeds the queue.
`default_nettype none
module aput_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [aput_pkg::IDX_W-1:0]    param_index,
   input  logic signed [31:0]            gradient,
   input  logic signed [31:0]            current_weight,
   input  logic                          first_in_pass,
   input  logic                          hold,
   input  logic [15:0]                   beta_first,
   input  logic [15:0]                   beta_second,
   input  logic [31:0]                   learning_rate,
   input  logic                          q_full,
   output logic                          q_push,
   output aput_pkg::item_type            q_data
);
   import aput_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_POW = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_MUL = 3'd4;
   localparam logic [2:0] ST_SAT = 3'd5;
   localparam logic [2:0] ST_DIV = 3'd6;
   localparam logic [2:0] ST_PUSH = 3'd7;

   logic [2:0]  state_ff, state_in;
   item_type    held_ff, held_in;
   logic [31:0] p1_ff, p1_in, p2_ff, p2_in, rate_ff, rate_in;
   sqrt_type    sq_ff, sq_in;
   logic [63:0] bit_ff, bit_in;
   logic        special_ff, special_in;
   logic [32:0] den_ff, den_in;
   logic [63:0] prod_ff, prod_in, rem_ff, rem_in, dsh_ff, dsh_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] s_val;
   logic        qbit;
   logic        accept;

   assign full = (state_ff != ST_IDLE) || q_full || hold;
   assign accept = push && !full;
   assign s_val = special_ff ? 33'h1_0000_0000 : {1'b0, sq_ff.root[31:0]};
   assign qbit = rem_ff >= dsh_ff;

   always_comb begin
      state_in = state_ff;
      held_in = held_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      rate_in = rate_ff;
      sq_in = sq_ff;
      bit_in = bit_ff;
      special_in = special_ff;
      den_in = den_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      q_push = 1'b0;
      q_data.idx = param_index;
      q_data.gradient = gradient;
      q_data.weight = current_weight;
      q_data.rate = rate_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (first_in_pass) begin
                  held_in = q_data;
                  state_in = ST_POW;
               end else begin
                  q_push = 1'b1;
               end
            end
         end
         ST_POW: begin
            p1_in = 32'((64'(p1_ff) * 64'(beta_first) + 64'd32768) >> 16);
            p2_in = 32'((64'(p2_ff) * 64'(beta_second) + 64'd32768) >> 16);
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            special_in = (p2_ff == 32'd0);
            sq_in.rem = {(~p2_ff) + 32'd1, 32'd0};
            sq_in.root = 64'd0;
            bit_in = 64'h4000_0000_0000_0000;
            cnt_in = 5'd31;
            den_in = 33'h1_0000_0000 - {1'b0, p1_ff};
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            sq_in = sqrt_step(sq_ff, bit_ff);
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = 64'(learning_rate) * 64'(s_val);
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if ({1'b0, prod_ff} >= {den_ff, 32'd0}) begin
               rate_in = ONE_Q32;
               state_in = ST_PUSH;
            end else begin
               rem_in = prod_ff;
               dsh_in = 64'(den_ff) << 31;
               quo_in = 32'd0;
               cnt_in = 5'd31;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (qbit) begin
               rem_in = rem_ff - dsh_ff;
            end
            quo_in = {quo_ff[30:0], qbit};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               rate_in = {quo_ff[30:0], qbit};
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            q_data = held_ff;
            q_data.rate = rate_ff;
            if (!q_full) begin
               q_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         p1_ff <= ONE_Q32;
         p2_ff <= ONE_Q32;
         rate_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         rate_ff <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      sq_ff <= sq_in;
      bit_ff <= bit_in;
      special_ff <= special_in;
      den_ff <= den_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

/* rtl/aput_queue.sv */
// Short queue of classified items between the front end and the update pipeline.
`default_nettype none
module aput_queue #(
   parameter int DEPTH = aput_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  aput_pkg::item_type push_data,
   output logic               full,
   input  logic               pop,
   output aput_pkg::item_type head,
   output logic               empty
);
   import aput_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        slot_ff [0:DEPTH-1];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

/* rtl/aput_back.sv */
// Update pipeline: moment stores, moment update, square root, divide and weight step.
`default_nettype none
module aput_back #(
   parameter int NUM_PARAMS = aput_pkg::DEFAULT_NUM_PARAMS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  aput_pkg::item_type         q_data,
   output logic                       q_pop,
   input  logic [15:0]                beta_first,
   input  logic [15:0]                beta_second,
   input  logic [15:0]                epsilon_term,
   output logic                       clearing,
   output logic                       empty,
   input  logic                       pop,
   output logic [aput_pkg::IDX_W-1:0] out_index,
   output logic signed [31:0]         new_weight,
   output logic                       saturated
);
   import aput_pkg::*;

   localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
   localparam int SQ_N = 32;
   localparam int DV_N = 34;

   typedef struct packed {
      logic               inr;
      logic [IDX_W-1:0]   idx;
      logic signed [31:0] weight;
   } tag_type;

   logic [31:0] fm_mem [0:NUM_PARAMS-1];
   logic [31:0] vm_mem [0:NUM_PARAMS-1];

   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          adv, issue, haz, q_inr;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [31:0]   fm_wd, vm_wd;

   logic               s1_vld_ff, s1_inr_ff;
   item_type           s1_item_ff;
   logic signed [31:0] fm_rd_ff;
   logic [31:0]        vm_rd_ff;

   logic               s2_vld_ff;
   tag_type            s2_tag_ff;
   logic [31:0]        s2_rate_ff, s2_vo_ff;
   logic signed [49:0] pm1_in, pm1_ff, pm2_in, pm2_ff;
   logic [31:0]        gabs;
   logic [63:0]        gsq_ff;

   logic               s3_vld_ff;
   tag_type            s3_tag_ff;
   logic [31:0]        s3_rate_ff, s3_vo_ff;
   logic signed [50:0] msum, mshr;
   logic signed [31:0] m_in, s3_m_ff;
   logic [42:0]        q_in, s3_q_ff;

   logic               s4_vld_ff;
   tag_type            s4_tag_ff;
   logic [31:0]        s4_rate_ff;
   logic signed [31:0] s4_m_ff;
   logic [47:0]        pv1_ff;
   logic [59:0]        pv2_ff;
   logic [63:0]        vsum;
   logic [31:0]        v_in;

   logic               sq_vld_ff [0:SQ_N];
   tag_type            sq_tag_ff [0:SQ_N];
   logic [31:0]        sq_rate_ff [0:SQ_N];
   logic signed [31:0] sq_m_ff [0:SQ_N];
   sqrt_type           sq_ff [0:SQ_N];

   logic               p_vld_ff, p_neg_ff;
   tag_type            p_tag_ff;
   logic [34:0]        d_raw, d_in, p_d_ff;
   logic [31:0]        m_abs;
   logic [63:0]        p_n_ff, n_round;

   logic               dv_vld_ff [0:DV_N];
   tag_type            dv_tag_ff [0:DV_N];
   logic               dv_neg_ff [0:DV_N];
   logic               dv_ovf_ff [0:DV_N];
   logic [34:0]        dv_d_ff [0:DV_N];
   logic [63:0]        dv_rem_ff [0:DV_N];
   logic [33:0]        dv_quo_ff [0:DV_N];

   logic [33:0]        delta;
   logic signed [35:0] nw;
   logic               nw_hi, nw_lo;
   logic               out_vld_ff, out_sat_ff, out_sat_in;
   logic [IDX_W-1:0]   out_idx_ff;
   logic signed [31:0] out_w_ff, out_w_in;

   assign adv = !out_vld_ff || pop;
   assign q_inr = 32'(q_data.idx) < 32'(NUM_PARAMS);
   assign haz = (s1_vld_ff && s1_inr_ff && s1_item_ff.idx == q_data.idx)
             || (s2_vld_ff && s2_tag_ff.inr && s2_tag_ff.idx == q_data.idx)
             || (s3_vld_ff && s3_tag_ff.inr && s3_tag_ff.idx == q_data.idx)
             || (s4_vld_ff && s4_tag_ff.inr && s4_tag_ff.idx == q_data.idx);
   assign issue = adv && !q_empty && !clr_ff && !haz;
   assign q_pop = issue;
   assign clearing = clr_ff;

   always_comb begin
      clr_in = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(NUM_PARAMS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign mem_we = clr_ff || (adv && s4_vld_ff && s4_tag_ff.inr);
   assign mem_wa = clr_ff ? clr_cnt_ff : AW'(s4_tag_ff.idx);
   assign fm_wd = clr_ff ? 32'd0 : s4_m_ff;
   assign vm_wd = clr_ff ? 32'd0 : v_in;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fm_mem[mem_wa] <= fm_wd;
         vm_mem[mem_wa] <= vm_wd;
      end
      if (adv) begin
         fm_rd_ff <= fm_mem[AW'(q_data.idx)];
         vm_rd_ff <= vm_mem[AW'(q_data.idx)];
      end
   end

   assign gabs = s1_item_ff.gradient[31] ? (~s1_item_ff.gradient + 32'd1)
                                         : s1_item_ff.gradient;
   assign pm1_in = $signed({1'b0, beta_first}) * fm_rd_ff;
   assign pm2_in = $signed({1'b0, 17'h1_0000 - {1'b0, beta_first}}) * s1_item_ff.gradient;

   assign msum = $signed({pm1_ff[49], pm1_ff}) + $signed({pm2_ff[49], pm2_ff})
               + 51'sd32768;
   assign mshr = msum >>> 16;
   assign m_in = (mshr > 51'sd2147483647) ? 32'sh7FFF_FFFF :
                 (mshr < -51'sd2147483648) ? 32'sh8000_0000 : mshr[31:0];
   assign q_in = 43'((gsq_ff + 64'd524288) >> 20);

   assign vsum = 64'(pv1_ff) + 64'(pv2_ff) + 64'd32768;
   assign v_in = (vsum[63:48] != 16'd0) ? 32'hFFFF_FFFF : vsum[47:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         sq_vld_ff[0] <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= q_data;
         s1_inr_ff <= q_inr;
         s2_tag_ff <= '{inr: s1_inr_ff, idx: s1_item_ff.idx, weight: s1_item_ff.weight};
         s2_rate_ff <= s1_item_ff.rate;
         s2_vo_ff <= vm_rd_ff;
         pm1_ff <= pm1_in;
         pm2_ff <= pm2_in;
         gsq_ff <= 64'(gabs) * 64'(gabs);
         s3_tag_ff <= s2_tag_ff;
         s3_rate_ff <= s2_rate_ff;
         s3_vo_ff <= s2_vo_ff;
         s3_m_ff <= m_in;
         s3_q_ff <= q_in;
         s4_tag_ff <= s3_tag_ff;
         s4_rate_ff <= s3_rate_ff;
         s4_m_ff <= s3_m_ff;
         pv1_ff <= 48'(64'(beta_second) * 64'(s3_vo_ff));
         pv2_ff <= 60'(64'(17'h1_0000 - {1'b0, beta_second}) * 64'(s3_q_ff));
         sq_tag_ff[0] <= s4_tag_ff;
         sq_rate_ff[0] <= s4_rate_ff;
         sq_m_ff[0] <= s4_m_ff;
         sq_ff[0] <= '{rem: {v_in, 32'd0}, root: 64'd0};
      end
   end

   for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_tag_ff[k+1] <= sq_tag_ff[k];
            sq_rate_ff[k+1] <= sq_rate_ff[k];
            sq_m_ff[k+1] <= sq_m_ff[k];
            sq_ff[k+1] <= sqrt_step(sq_ff[k], 64'd1 << (62 - 2 * k));
         end
      end
   end

   assign d_raw = {1'b0, sq_ff[SQ_N].root[31:0], 2'b00} + 35'(epsilon_term);
   assign d_in = (d_raw == 35'd0) ? 35'd1 : d_raw;
   assign m_abs = sq_m_ff[SQ_N][31] ? (~sq_m_ff[SQ_N] + 32'd1) : sq_m_ff[SQ_N];
   assign n_round = p_n_ff + 64'(p_d_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         p_vld_ff <= sq_vld_ff[SQ_N];
         dv_vld_ff[0] <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_tag_ff <= sq_tag_ff[SQ_N];
         p_neg_ff <= sq_m_ff[SQ_N][31];
         p_d_ff <= d_in;
         p_n_ff <= 64'(sq_rate_ff[SQ_N]) * 64'(m_abs);
         dv_tag_ff[0] <= p_tag_ff;
         dv_neg_ff[0] <= p_neg_ff;
         dv_d_ff[0] <= p_d_ff;
         dv_rem_ff[0] <= n_round;
         dv_quo_ff[0] <= 34'd0;
         dv_ovf_ff[0] <= {5'd0, n_round} >= {p_d_ff, 34'd0};
      end
   end

   for (genvar i = 0; i < DV_N; i++) begin : g_div
      logic [68:0] trial;
      logic        take;
      assign trial = 69'(dv_d_ff[i]) << (DV_N - 1 - i);
      assign take = {5'd0, dv_rem_ff[i]} >= trial;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[i+1] <= dv_vld_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_tag_ff[i+1] <= dv_tag_ff[i];
            dv_neg_ff[i+1] <= dv_neg_ff[i];
            dv_ovf_ff[i+1] <= dv_ovf_ff[i];
            dv_d_ff[i+1] <= dv_d_ff[i];
            dv_rem_ff[i+1] <= take ? (dv_rem_ff[i] - trial[63:0]) : dv_rem_ff[i];
            dv_quo_ff[i+1] <= dv_quo_ff[i] | (34'(take) << (DV_N - 1 - i));
         end
      end
   end

   assign delta = (dv_ovf_ff[DV_N] || dv_quo_ff[DV_N] > 34'h2_0000_0000) ? 34'h2_0000_0000
                                                                         : dv_quo_ff[DV_N];
   assign nw = dv_neg_ff[DV_N]
             ? $signed({{4{dv_tag_ff[DV_N].weight[31]}}, dv_tag_ff[DV_N].weight})
               + $signed({2'b00, delta})
             : $signed({{4{dv_tag_ff[DV_N].weight[31]}}, dv_tag_ff[DV_N].weight})
               - $signed({2'b00, delta});
   assign nw_hi = nw > 36'sd2147483647;
   assign nw_lo = nw < -36'sd2147483648;

   always_comb begin
      out_w_in = dv_tag_ff[DV_N].weight;
      out_sat_in = 1'b0;
      if (dv_tag_ff[DV_N].inr) begin
         out_sat_in = nw_hi || nw_lo;
         out_w_in = nw_hi ? 32'sh7FFF_FFFF : nw_lo ? 32'sh8000_0000 : nw[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= dv_vld_ff[DV_N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_idx_ff <= dv_tag_ff[DV_N].idx;
         out_w_ff <= out_w_in;
         out_sat_ff <= out_sat_in;
      end
   end

   assign empty = !out_vld_ff;
   assign out_index = out_idx_ff;
   assign new_weight = out_w_ff;
   assign saturated = out_sat_ff;

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clr_ff |=> !clr_ff)
      else $error("moment clear restarted");

   a_no_item_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !s4_vld_ff && !s1_vld_ff)
      else $error("item in flight during moment clear");

   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && s1_inr_ff && s4_vld_ff && s4_tag_ff.inr |-> s1_item_ff.idx != s4_tag_ff.idx)
      else $error("read of a moment entry still being updated");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_sat_ff |-> out_w_ff == 32'sh7FFF_FFFF || out_w_ff == 32'sh8000_0000)
      else $error("saturated flag without clipped weight");
endmodule
`default_nettype wire

/* rtl/adam_parameter_update_top.sv */
// Adam parameter update block: configuration registers, front end, queue and update pipeline.
//
// Input channel: an item (index, gradient, weight, pass-start flag) is taken on a clock edge
// with push high and full low. Result channel: while empty is low the oldest result
// (index, new weight, saturation flag) is on the rsp_ ports; pop high takes it.
// Configuration: one register per beat on valid/ready (ready is always high), index on
// csr_index; write only while no item is in flight.
// Throughput: one item per cycle while full is low. An item with the pass-start flag holds full
// high while the front end iterates the beta powers, square root and rate divide.
// An item waits in the update pipeline behind an earlier item of the same index until that
// one has written its moments.
// Path: each result passes through the 32-step square root pipeline and
// the 34-step divide pipeline.
// Reset: the moment stores are cleared one entry per cycle, all NUM_PARAMS entries, with full
// held high; configuration writes are taken meanwhile.
// Stall: while results are not popped the whole pipeline holds; the queue then fills and
// full goes high.
`default_nettype none
module adam_parameter_update_top #(
   parameter int NUM_PARAMS = aput_pkg::DEFAULT_NUM_PARAMS,
   parameter int QUEUE_DEPTH = aput_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [aput_pkg::IDX_W-1:0]     req_param_index,
   input  logic signed [31:0]             req_gradient,
   input  logic signed [31:0]             req_current_weight,
   input  logic                           req_first_in_pass,
   output logic                           empty,
   input  logic                           pop,
   output logic [aput_pkg::IDX_W-1:0]     rsp_out_index,
   output logic signed [31:0]             rsp_new_weight,
   output logic                           rsp_saturated,
   input  logic                           valid,
   output logic                           ready,
   input  logic [aput_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);
   import aput_pkg::*;

   logic [15:0] beta_first_ff, beta_second_ff, epsilon_term_ff;
   logic [31:0] learning_rate_ff;
   logic        csr_we;
   logic        q_push, q_full, q_pop, q_empty, clearing;
   item_type    q_in_data, q_head;

   assign ready = 1'b1;
   assign csr_we = valid && ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_first_ff <= BETA_FIRST_RST;
         beta_second_ff <= BETA_SECOND_RST;
         epsilon_term_ff <= EPSILON_TERM_RST;
         learning_rate_ff <= LEARNING_RATE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BETA_FIRST: begin
               beta_first_ff <= csr_data[15:0];
            end
            CSR_BETA_SECOND: begin
               beta_second_ff <= csr_data[15:0];
            end
            CSR_EPSILON_TERM: begin
               epsilon_term_ff <= csr_data[15:0];
            end
            CSR_LEARNING_RATE: begin
               learning_rate_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   aput_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .param_index   (req_param_index),
      .gradient      (req_gradient),
      .current_weight(req_current_weight),
      .first_in_pass (req_first_in_pass),
      .hold          (clearing),
      .beta_first    (beta_first_ff),
      .beta_second   (beta_second_ff),
      .learning_rate (learning_rate_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_in_data)
   );

   aput_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in_data),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   aput_back #(
      .NUM_PARAMS(NUM_PARAMS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (q_head),
      .q_pop       (q_pop),
      .beta_first  (beta_first_ff),
      .beta_second (beta_second_ff),
      .epsilon_term(epsilon_term_ff),
      .clearing    (clearing),
      .empty       (empty),
      .pop         (pop),
      .out_index   (rsp_out_index),
      .new_weight  (rsp_new_weight),
      .saturated   (rsp_saturated)
   );
endmodule
`default_nettype wire

/* verif/adam_update_checker.sv */
// Checker for the Adam update block: watches the channels, predicts new weights, compares.
`timescale 1ns / 1ps
module adam_update_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           full,
   input  logic [aput_pkg::IDX_W-1:0]     req_param_index,
   input  logic signed [31:0]             req_gradient,
   input  logic signed [31:0]             req_current_weight,
   input  logic                           req_first_in_pass,
   input  logic                           empty,
   input  logic                           pop,
   input  logic [aput_pkg::IDX_W-1:0]     rsp_out_index,
   input  logic signed [31:0]             rsp_new_weight,
   input  logic                           rsp_saturated,
   input  logic                           valid,
   input  logic                           ready,
   input  logic [aput_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data,
   output int                             fail_count,
   output int                             pending,
   output int                             weights_seen,
   output int                             clipped_seen
);
   import aput_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic signed [31:0] weight;
      logic               sat;
   } weight_beat_type;

   weight_beat_type weight_q[$];
   logic [31:0]    m_store [DEFAULT_NUM_PARAMS];
   logic [31:0]    v_store [DEFAULT_NUM_PARAMS];
   logic [31:0]    steps, pow1, pow2, rate;
   logic [15:0]    b1, b2, eps;
   logic [31:0]    lr;

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic advance_pass();
      logic [63:0] x, s, den, r;
      steps = steps + 1;
      pow1 = 32'((64'(pow1) * b1 + 64'd32768) >> 16);
      pow2 = 32'((64'(pow2) * b2 + 64'd32768) >> 16);
      x = (64'd1 << 32) - pow2;
      s = (x == (64'd1 << 32)) ? x : int_sqrt(x << 32);
      den = (64'd1 << 32) - pow1;
      r = (64'(lr) * s) / den;
      rate = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
   endtask

   function automatic longint floor_div16(input longint x);
      if (x >= 0) return x >>> 16;
      return -longint'((longint'(-x) + 65535) >>> 16);
   endfunction

   task automatic predict_weight(input logic [IDX_W-1:0] idx, input logic signed [31:0] g32,
                                 input logic signed [31:0] w32, input logic fip);
      weight_beat_type e;
      longint       g, w, m, nw;
      logic [63:0]  mag, q, vn, d, delta;
      logic [31:0]  v;
      if (fip) advance_pass();
      g = g32;
      w = w32;
      e.idx = idx;
      e.sat = 1'b0;
      if (int'(idx) >= DEFAULT_NUM_PARAMS) begin
         e.weight = w32;
         weight_q.push_back(e);
         return;
      end
      m = floor_div16(longint'(b1) * longint'($signed(m_store[idx]))
                      + longint'(65536 - int'(b1)) * g + 32768);
      if (m > 64'sd2147483647) m = 2147483647;
      if (m < -64'sd2147483648) m = -64'sd2147483648;
      m_store[idx] = m[31:0];
      mag = (g < 0) ? -g : g;
      q = (mag * mag + (64'd1 << 19)) >> 20;
      vn = (64'(b2) * v_store[idx] + 64'(65536 - int'(b2)) * q + 64'd32768) >> 16;
      v = (vn > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vn[31:0];
      v_store[idx] = v;
      d = 4 * int_sqrt(64'(v) << 32) + eps;
      if (d == 0) d = 1;
      mag = (m < 0) ? -m : m;
      delta = (64'(rate) * mag + d / 2) / d;
      if (delta > (64'd1 << 33)) delta = 64'd1 << 33;
      nw = (m < 0) ? w + longint'(delta) : w - longint'(delta);
      if (nw > 64'sd2147483647) begin
         nw = 2147483647;
         e.sat = 1'b1;
      end else if (nw < -64'sd2147483648) begin
         nw = -64'sd2147483648;
         e.sat = 1'b1;
      end
      e.weight = nw[31:0];
      weight_q.push_back(e);
   endtask

   always @(posedge clock) begin
      weight_beat_type e;
      if (reset) begin
         for (int i = 0; i < DEFAULT_NUM_PARAMS; i++) begin
            m_store[i] = 0;
            v_store[i] = 0;
         end
         steps = 0;
         pow1 = ONE_Q32;
         pow2 = ONE_Q32;
         rate = 0;
         b1 = BETA_FIRST_RST;
         b2 = BETA_SECOND_RST;
         eps = EPSILON_TERM_RST;
         lr = LEARNING_RATE_RST;
         weight_q.delete();
         fail_count = 0;
         weights_seen = 0;
         clipped_seen = 0;
      end else begin
         if (valid && ready) begin
            case (csr_index)
               CSR_BETA_FIRST: b1 = csr_data[15:0];
               CSR_BETA_SECOND: b2 = csr_data[15:0];
               CSR_EPSILON_TERM: eps = csr_data[15:0];
               CSR_LEARNING_RATE: lr = csr_data;
               default: ;
            endcase
         end
         if (pop && !empty) begin
            weights_seen++;
            if (rsp_saturated) clipped_seen++;
            if (weight_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected beat: idx %0d weight %0d", rsp_out_index, rsp_new_weight);
            end else begin
               e = weight_q.pop_front();
               if (e.idx !== rsp_out_index || e.weight !== rsp_new_weight
                   || e.sat !== rsp_saturated) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp idx %0d w %0d sat %0b, got idx %0d w %0d sat %0b",
                              e.idx, e.weight, e.sat, rsp_out_index, rsp_new_weight,
                              rsp_saturated);
               end
            end
         end
         if (push && !full)
            predict_weight(req_param_index, req_gradient, req_current_weight, req_first_in_pass);
      end
      pending = weight_q.size();
   end
endmodule

/* verif/tb.sv */
// Testbench top for the Adam update block: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb;
   import aput_pkg::*;

   logic                 clock, reset;
   logic                 push, full, empty, pop;
   logic [IDX_W-1:0]     req_param_index;
   logic signed [31:0]   req_gradient, req_current_weight;
   logic                 req_first_in_pass;
   logic [IDX_W-1:0]     rsp_out_index;
   logic signed [31:0]   rsp_new_weight;
   logic                 rsp_saturated;
   logic                 valid, ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;
   int                   fail_count, pending, weights_seen, clipped_seen;
   int                   idle_cycles;
   bit                   pop_idle_ok, hold_off;
   int                   items_sent;

   adam_parameter_update_top i_dut (.*);

   adam_update_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      push = 0;
      pop = 0;
      valid = 0;
      csr_index = 0;
      csr_data = 0;
      req_param_index = 0;
      req_gradient = 0;
      req_current_weight = 0;
      req_first_in_pass = 0;
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: random idle bursts, a long hold-off when asked
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            pop <= 0;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end else if (pop_idle_ok && $urandom_range(0, 7) == 0) begin
            pop <= 0;
            n = $urandom_range(1, 4);
            repeat (n) @(negedge clock);
         end else begin
            pop <= 1;
            @(negedge clock);
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!ready) @(posedge clock);
      @(negedge clock);
      valid <= 0;
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_item(input logic [IDX_W-1:0] idx, input logic [31:0] g,
                            input logic [31:0] w, input logic fip, input bit gaps);
      int n;
      if (gaps && $urandom_range(0, 5) == 0) begin
         push <= 0;
         n = $urandom_range(1, 4);
         repeat (n) @(negedge clock);
      end
      push <= 1;
      req_param_index <= idx;
      req_gradient <= g;
      req_current_weight <= w;
      req_first_in_pass <= fip;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 65535) - 32768;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_pass(input int count, input bit gaps);
      logic [IDX_W-1:0] base;
      base = IDX_W'($urandom_range(0, 4095 - count));
      for (int i = 0; i < count; i++)
         send_item(base + i[IDX_W-1:0], rand_field(), rand_field(), i == 0, gaps);
   endtask

   task automatic end_phase();
      push <= 0;
      drain();
   endtask

   initial begin
      items_sent = 0;
      pop_idle_ok = 0;
      hold_off = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: before any pass, extremes, zero epsilon, repeated index
      write_reg(CSR_EPSILON_TERM, 0);
      send_item(0, 0, 0, 0, 0);
      send_item(4095, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      send_item(1, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0);
      send_item(1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
      send_item(1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
      send_item(2, 0, 32'h1234_5678, 0, 0);
      send_item(3, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0);
      end_phase();
      write_reg(CSR_LEARNING_RATE, 32'hFFFF_FFFF);
      write_reg(CSR_BETA_FIRST, 0);
      write_reg(CSR_BETA_SECOND, 0);
      send_item(5, 32'h7FFF_FFFF, 32'h7FFF_FFF0, 1, 0);
      send_item(6, 32'h8000_0000, 32'h8000_0010, 0, 0);
      send_item(7, 32'h0100_0000, 32'h0000_0000, 1, 0);
      send_item(8, 32'hFF00_0000, 32'h0000_0000, 0, 0);
      end_phase();
      write_reg(CSR_BETA_FIRST, 16'hFFFF);
      write_reg(CSR_BETA_SECOND, 16'hFFFF);
      write_reg(CSR_EPSILON_TERM, 16'hFFFF);
      write_reg(CSR_LEARNING_RATE, 0);
      send_item(9, 32'h7FFF_FFFF, 32'h0, 1, 0);
      send_item(9, 32'h8000_0000, 32'h0, 1, 0);
      end_phase();

      // random phases under varied settings
      pop_idle_ok = 1;
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_BETA_FIRST, (ph == 1) ? 0 : (ph == 2) ? 16'hFFFF : $urandom_range(0, 65535));
         write_reg(CSR_BETA_SECOND, (ph == 3) ? 0 : $urandom_range(60000, 65535));
         write_reg(CSR_EPSILON_TERM, (ph == 4) ? 0 : $urandom_range(0, 65535));
         write_reg(CSR_LEARNING_RATE, (ph == 2) ? 32'hFFFF_FFFF : $urandom);
         if (ph == 1) hold_off = 1;
         for (int p = 0; p < 4; p++) run_pass($urandom_range(10, 40), 1);
         end_phase();
      end

      // tail without idling
      pop_idle_ok = 0;
      run_pass(40, 0);
      run_pass(40, 0);
      end_phase();

      $display("covered %0d items and %0d weight beats, %0d clipped, with a long receiver stall",
               items_sent, weights_seen, clipped_seen);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
